[hdl/uwt_pkg.sv]
// ----------------------------------------------------------------------------
// uwt_pkg: shared types and helpers for the upwind triangle element matrix
// Field widths, lane payload structs and the divide-by-three helpers used
// by the flux pipeline.
// ----------------------------------------------------------------------------
package uwt_pkg;

  // Field widths
  localparam int COORD_W   = 24;           // Q12.12 input coordinate
  localparam int DIFF_W    = COORD_W + 2;  // y_n + y_i - 2*y_k
  localparam int EDGE_W    = COORD_W + 1;  // y_n - y_i
  localparam int PROD_W    = 50;           // difference times velocity
  localparam int CROSS_W   = PROD_W + 1;   // difference of two products
  localparam int MAG_W     = 49;           // half magnitude of a cross product
  localparam int SPLIT_W   = 25;           // low chunk of the magnitude
  localparam int HI_W      = MAG_W - SPLIT_W;
  localparam int DIV3_W    = SPLIT_W + 2;  // operand of one divide-by-three step
  localparam int ENTRY_W   = 56;           // Q32.24 matrix entry
  localparam int IN_DATA_W = 8 * COORD_W;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 9 * ENTRY_W;

  // floor((2^32 - 1) / 3): estimate is low by at most one for 27-bit operands
  localparam logic [31:0] DIV3_RECIP = 32'h5555_5555;
  localparam int RECIP_SH = 32;
  localparam int RECIP_P_W = DIV3_W + RECIP_SH;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_w_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [MAG_W:0]     sum_t;
  typedef logic        [DIV3_W-1:0]  div3_in_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t      [2:0]         row_t;

  // One triangle request
  typedef struct packed {
    coord_t [2:0] x;
    coord_t [2:0] y;
    coord_t       vx;
    coord_t       vy;
    logic   [2:0] bnd;
  } tri_t;

  // Per-edge cross products; be marks an edge with both ends on the boundary
  typedef struct packed {
    cross_w_t [2:0] c;
    cross_w_t [2:0] e;
    logic     [2:0] be;
  } cross_res_t;

  // Per-edge flux magnitude, its sign and the boundary outflow
  typedef struct packed {
    mag_t [2:0] q;
    logic [2:0] neg;
    mag_t [2:0] g;
  } flux_t;

  typedef struct packed {
    row_t [2:0] a;
  } matrix_t;

  typedef struct packed {
    div3_in_t   quo;
    logic [1:0] rem;
  } div3_res_t;

  // Quotient estimate by reciprocal multiply, never above the true quotient
  function automatic div3_in_t div3_est(input div3_in_t x);
    logic [RECIP_P_W-1:0] p;
    p = RECIP_P_W'(x) * RECIP_P_W'(DIV3_RECIP);
    return p[RECIP_P_W-1:RECIP_SH];
  endfunction

  // Correct an estimate that may be one low and return the remainder
  function automatic div3_res_t div3_fix(input div3_in_t x, input div3_in_t q0);
    div3_in_t  t;
    div3_res_t r;
    t = x - (q0 + (q0 << 1));
    if (t >= div3_in_t'(3)) begin
      r.quo = q0 + div3_in_t'(1);
      r.rem = 2'(t - div3_in_t'(3));
    end else begin
      r.quo = q0;
      r.rem = t[1:0];
    end
    return r;
  endfunction

endpackage

[hdl/uwt_cross.sv]
// ----------------------------------------------------------------------------
// uwt_cross: edge cross products
// Three stages: coordinate differences, products with the velocity, and the
// cross-product differences for the interface flux and the boundary flux.
// ----------------------------------------------------------------------------
module uwt_cross import uwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tri_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cross_res_t out_data_o
);

  localparam int Stages = 3;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_up;
  logic [Stages:0]   rdy;

  // Stage handshake: a stage loads when it is empty or its successor moves
  assign vld_up      = {vld_q[Stages-2:0], in_valid_i};
  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_up & rdy[Stages-1:0]) | (vld_q & ~rdy[Stages-1:0]);
    end
  end

  diff_t  [2:0] dy_d, dx_d, dy_q, dx_q;
  edge_t  [2:0] ey_d, ex_d, ey_q, ex_q;
  logic   [2:0] be_d, be1_q, be2_q;
  coord_t       vx1_q, vy1_q;
  prod_t  [2:0] pdy_d, pdx_d, pey_d, pex_d;
  prod_t  [2:0] pdy_q, pdx_q, pey_q, pex_q;
  cross_w_t [2:0] c_d, e_d;
  cross_res_t   res_q;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam int N = (l + 1) % 3;
    localparam int K = (l + 2) % 3;

    // Differences toward the opposite vertex and along the edge
    assign dy_d[l] = diff_t'(in_data_i.y[N]) + diff_t'(in_data_i.y[l])
                   - (diff_t'(in_data_i.y[K]) <<< 1);
    assign dx_d[l] = diff_t'(in_data_i.x[N]) + diff_t'(in_data_i.x[l])
                   - (diff_t'(in_data_i.x[K]) <<< 1);
    assign ey_d[l] = edge_t'(in_data_i.y[N]) - edge_t'(in_data_i.y[l]);
    assign ex_d[l] = edge_t'(in_data_i.x[N]) - edge_t'(in_data_i.x[l]);
    assign be_d[l] = in_data_i.bnd[l] & in_data_i.bnd[N];

    // Products with the velocity components
    assign pdy_d[l] = prod_t'(dy_q[l]) * prod_t'(vx1_q);
    assign pdx_d[l] = prod_t'(dx_q[l]) * prod_t'(vy1_q);
    assign pey_d[l] = prod_t'(ey_q[l]) * prod_t'(vx1_q);
    assign pex_d[l] = prod_t'(ex_q[l]) * prod_t'(vy1_q);

    // Cross products
    assign c_d[l] = cross_w_t'(pdy_q[l]) - cross_w_t'(pdx_q[l]);
    assign e_d[l] = cross_w_t'(pey_q[l]) - cross_w_t'(pex_q[l]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dy_q  <= dy_d;
      dx_q  <= dx_d;
      ey_q  <= ey_d;
      ex_q  <= ex_d;
      be1_q <= be_d;
      vx1_q <= in_data_i.vx;
      vy1_q <= in_data_i.vy;
    end
    if (rdy[1]) begin
      pdy_q <= pdy_d;
      pdx_q <= pdx_d;
      pey_q <= pey_d;
      pex_q <= pex_d;
      be2_q <= be1_q;
    end
    if (rdy[2]) begin
      res_q.c  <= c_d;
      res_q.e  <= e_d;
      res_q.be <= be2_q;
    end
  end

  assign out_data_o = res_q;

endmodule

[hdl/uwt_div6.sv]
// ----------------------------------------------------------------------------
// uwt_div6: truncating divide of the interface flux by six
// Halves the magnitude, then divides by three in two chunks, each as a
// reciprocal multiply followed by a one-step correction. Also forms the
// halved positive boundary outflow.
// ----------------------------------------------------------------------------
module uwt_div6 import uwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cross_res_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output flux_t      out_data_o
);

  localparam int Stages = 5;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_up;
  logic [Stages:0]   rdy;

  // Stage handshake: a stage loads when it is empty or its successor moves
  assign vld_up      = {vld_q[Stages-2:0], in_valid_i};
  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_up & rdy[Stages-1:0]) | (vld_q & ~rdy[Stages-1:0]);
    end
  end

  cross_w_t  [2:0] abs_c;
  mag_t      [2:0] mag1_d, g1_d, mag1_q, g1_q, mag2_q, g2_q, g3_q, g4_q;
  logic      [2:0] neg1_q, neg2_q, neg3_q, neg4_q;
  div3_in_t  [2:0] qa0_d, qa0_q;
  div3_res_t [2:0] fix_a, fix_b;
  logic [2:0][HI_W-1:0]    qa_d, qa_q, qa4_q;
  logic [2:0][1:0]         ra_q;
  logic [2:0][SPLIT_W-1:0] ml_q;
  div3_in_t  [2:0] v_d, v4_q, qb0_d, qb0_q;
  mag_t      [2:0] q_d;
  flux_t           res_q;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    // Sign and halved magnitude; boundary outflow only when positive
    assign abs_c[l]  = in_data_i.c[l][CROSS_W-1] ? (cross_w_t'(0) - in_data_i.c[l])
                                                 : in_data_i.c[l];
    assign mag1_d[l] = abs_c[l][MAG_W:1];
    assign g1_d[l]   = (in_data_i.be[l] && (in_data_i.e[l] > cross_w_t'(1)))
                     ? in_data_i.e[l][MAG_W:1] : '0;

    // High chunk: estimate, then correct
    assign qa0_d[l] = div3_est(div3_in_t'(mag1_q[l][MAG_W-1:SPLIT_W]));
    assign fix_a[l] = div3_fix(div3_in_t'(mag2_q[l][MAG_W-1:SPLIT_W]), qa0_q[l]);
    assign qa_d[l]  = fix_a[l].quo[HI_W-1:0];

    // Low chunk with the high remainder carried in
    assign v_d[l]   = {ra_q[l], ml_q[l]};
    assign qb0_d[l] = div3_est(v_d[l]);
    assign fix_b[l] = div3_fix(v4_q[l], qb0_q[l]);
    assign q_d[l]   = {qa4_q[l], fix_b[l].quo[SPLIT_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mag1_q <= mag1_d;
      g1_q   <= g1_d;
      neg1_q <= {in_data_i.c[2][CROSS_W-1], in_data_i.c[1][CROSS_W-1],
                 in_data_i.c[0][CROSS_W-1]};
    end
    if (rdy[1]) begin
      mag2_q <= mag1_q;
      g2_q   <= g1_q;
      neg2_q <= neg1_q;
      qa0_q  <= qa0_d;
    end
    if (rdy[2]) begin
      qa_q   <= qa_d;
      ra_q[0] <= fix_a[0].rem;
      ra_q[1] <= fix_a[1].rem;
      ra_q[2] <= fix_a[2].rem;
      ml_q[0] <= mag2_q[0][SPLIT_W-1:0];
      ml_q[1] <= mag2_q[1][SPLIT_W-1:0];
      ml_q[2] <= mag2_q[2][SPLIT_W-1:0];
      g3_q   <= g2_q;
      neg3_q <= neg2_q;
    end
    if (rdy[3]) begin
      qa4_q  <= qa_q;
      v4_q   <= v_d;
      qb0_q  <= qb0_d;
      g4_q   <= g3_q;
      neg4_q <= neg3_q;
    end
    if (rdy[4]) begin
      res_q.q   <= q_d;
      res_q.neg <= neg4_q;
      res_q.g   <= g4_q;
    end
  end

  assign out_data_o = res_q;

endmodule

[hdl/uwt_assemble.sv]
// ----------------------------------------------------------------------------
// uwt_assemble: scatter of edge fluxes into the element matrix
// First stage routes each flux to its column by sign and forms partial
// diagonal sums; second stage finishes the diagonals and negates the
// off-diagonal terms into the output register.
// ----------------------------------------------------------------------------
module uwt_assemble import uwt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  flux_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output matrix_t out_data_o
);

  localparam int Stages = 2;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_up;
  logic [Stages:0]   rdy;

  // Stage handshake: a stage loads when it is empty or its successor moves
  assign vld_up      = {vld_q[Stages-2:0], in_valid_i};
  assign rdy[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_up & rdy[Stages-1:0]) | (vld_q & ~rdy[Stages-1:0]);
    end
  end

  logic   [2:0] fpos;
  sum_t   [2:0] da_d, db_d, da_q, db_q;
  mag_t   [2:0] lo_d, hi_d, lo_q, hi_q;
  entry_t [2:0] diag, off_lo, off_hi;
  matrix_t      mat_d, mat_q;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam int P = (l + 2) % 3;

    // A positive flux leaves column l; zero or negative goes to the next one
    assign fpos[l] = in_data_i.neg[l] & (|in_data_i.q[l]);
    assign da_d[l] = sum_t'(fpos[l] ? in_data_i.q[l] : '0)
                   + sum_t'(fpos[P] ? '0 : in_data_i.q[P]);
    assign db_d[l] = sum_t'(in_data_i.g[l]) + sum_t'(in_data_i.g[P]);
    assign lo_d[l] = fpos[l] ? in_data_i.q[l] : '0;
    assign hi_d[l] = fpos[l] ? '0 : in_data_i.q[l];

    // Sums stay below 2^51, well inside the entry range, so no overflow occurs
    assign diag[l]   = entry_t'({1'b0, da_q[l]} + {1'b0, db_q[l]});
    assign off_lo[l] = entry_t'(0) - entry_t'(lo_q[l]);
    assign off_hi[l] = entry_t'(0) - entry_t'(hi_q[l]);
  end

  // Place each term at its row and column
  always_comb begin
    mat_d.a[0][0] = diag[0];
    mat_d.a[1][1] = diag[1];
    mat_d.a[2][2] = diag[2];
    mat_d.a[0][1] = off_hi[0];
    mat_d.a[1][0] = off_lo[0];
    mat_d.a[1][2] = off_hi[1];
    mat_d.a[2][1] = off_lo[1];
    mat_d.a[2][0] = off_hi[2];
    mat_d.a[0][2] = off_lo[2];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      da_q <= da_d;
      db_q <= db_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (rdy[1]) begin
      mat_q <= mat_d;
    end
  end

  assign out_data_o = mat_q;

endmodule

[hdl/upwind_triangle_element_matrix.sv]
// ----------------------------------------------------------------------------
// upwind_triangle_element_matrix: upwind P1 finite-volume element matrix
// Latency: ten register stages from the accepted input to m_axis_tvalid.
// Throughput: one triangle per cycle; each of the ten stages holds its own
// valid bit, so a stalled output only stops the stages behind it once full.
// Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module upwind_triangle_element_matrix import uwt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
  // velocity_x, velocity_y (24 bits each)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // boundary0, boundary1, boundary2
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // entry_r0_c0, entry_r0_c1, entry_r0_c2, entry_r1_c0, entry_r1_c1,
  // entry_r1_c2, entry_r2_c0, entry_r2_c1, entry_r2_c2 (56 bits each)
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  tri_t       tri_in;
  cross_res_t cross_res;
  flux_t      flux;
  matrix_t    mat;
  logic       cross_valid, cross_ready;
  logic       flux_valid, flux_ready;

  // Unpack the triangle request
  always_comb begin
    tri_in.x[0] = s_axis_tdata[0*COORD_W +: COORD_W];
    tri_in.y[0] = s_axis_tdata[1*COORD_W +: COORD_W];
    tri_in.x[1] = s_axis_tdata[2*COORD_W +: COORD_W];
    tri_in.y[1] = s_axis_tdata[3*COORD_W +: COORD_W];
    tri_in.x[2] = s_axis_tdata[4*COORD_W +: COORD_W];
    tri_in.y[2] = s_axis_tdata[5*COORD_W +: COORD_W];
    tri_in.vx   = s_axis_tdata[6*COORD_W +: COORD_W];
    tri_in.vy   = s_axis_tdata[7*COORD_W +: COORD_W];
    tri_in.bnd  = s_axis_tuser;
  end

  uwt_cross u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (tri_in),
    .out_valid_o (cross_valid),
    .out_ready_i (cross_ready),
    .out_data_o  (cross_res)
  );

  uwt_div6 u_div6 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cross_valid),
    .in_ready_o  (cross_ready),
    .in_data_i   (cross_res),
    .out_valid_o (flux_valid),
    .out_ready_i (flux_ready),
    .out_data_o  (flux)
  );

  uwt_assemble u_assemble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (flux_valid),
    .in_ready_o  (flux_ready),
    .in_data_i   (flux),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (mat)
  );

  // Pack the matrix row by row, row 0 column 0 lowest
  always_comb begin
    m_axis_tdata[0*ENTRY_W +: ENTRY_W] = mat.a[0][0];
    m_axis_tdata[1*ENTRY_W +: ENTRY_W] = mat.a[0][1];
    m_axis_tdata[2*ENTRY_W +: ENTRY_W] = mat.a[0][2];
    m_axis_tdata[3*ENTRY_W +: ENTRY_W] = mat.a[1][0];
    m_axis_tdata[4*ENTRY_W +: ENTRY_W] = mat.a[1][1];
    m_axis_tdata[5*ENTRY_W +: ENTRY_W] = mat.a[1][2];
    m_axis_tdata[6*ENTRY_W +: ENTRY_W] = mat.a[2][0];
    m_axis_tdata[7*ENTRY_W +: ENTRY_W] = mat.a[2][1];
    m_axis_tdata[8*ENTRY_W +: ENTRY_W] = mat.a[2][2];
  end

endmodule
